### hdl/smfr_pkg.sv
// Package for the SPI master register block with its flash stand-in.
// Holds sizes, register offsets, field codes and the flash address table.
// No dependencies; used by the interfaces and by the top level.
package smfr_pkg;

    // Depth of the receive byte FIFO and size of the simulated flash.
    localparam int RX_DEPTH    = 16;
    localparam int FLASH_BYTES = 256;

    localparam int RX_IDX_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
    localparam int FL_PTR_W  = (FLASH_BYTES > 1) ? $clog2(FLASH_BYTES) : 1;

    // Field widths of the bus access and of its result.
    localparam int OFS_W  = 12;
    localparam int SIZE_W = 4;
    localparam int DATA_W = 32;

    // Access directions.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register offsets.
    localparam logic [OFS_W-1:0] OFS_CTRL   = 12'h000;
    localparam logic [OFS_W-1:0] OFS_DIV    = 12'h004;
    localparam logic [OFS_W-1:0] OFS_TX     = 12'h008;
    localparam logic [OFS_W-1:0] OFS_RX     = 12'h00C;
    localparam logic [OFS_W-1:0] OFS_STATUS = 12'h010;
    localparam logic [OFS_W-1:0] OFS_IE     = 12'h014;
    localparam logic [OFS_W-1:0] OFS_IS     = 12'h018;
    localparam logic [OFS_W-1:0] OFS_CAP    = 12'h01C;
    localparam logic [OFS_W-1:0] OFS_LIMIT  = OFS_CAP;

    // Control register fields and reset value.
    localparam logic [DATA_W-1:0] CTRL_RESET   = 32'h0000_00F1;
    localparam logic [DATA_W-1:0] CS_MASK      = 32'h0000_00F0;
    localparam int                LOOPBACK_BIT = 3;

    // Flash read command byte.
    localparam logic [7:0] CMD_READ = 8'h03;

    // Busy countdown loaded by a transmit.
    localparam logic [1:0] BUSY_LOAD = 2'd2;

    // Capability word: version, chip select count, FIFO depths.
    localparam logic [DATA_W-1:0] CAP_VALUE =
        {8'h01, 8'h04, 8'(RX_DEPTH), 8'(RX_DEPTH)};

    // Flash address byte reduced to a flash pointer, built at elaboration.
    typedef logic [FL_PTR_W-1:0] addr_tab_t [256];

    function automatic addr_tab_t build_addr_tab();
        addr_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = FL_PTR_W'(i % FLASH_BYTES);
        end
        return t;
    endfunction

    localparam addr_tab_t ADDR_TAB = build_addr_tab();

endpackage

### hdl/smfr_req_if.sv
// Request channel: one bus access per beat.
// Depends on smfr_pkg for field widths.
interface smfr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [smfr_pkg::OFS_W-1:0]    reg_offset;
    logic [smfr_pkg::SIZE_W-1:0]   access_bytes;
    logic [smfr_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output func, output reg_offset,
                    output access_bytes, output write_data, input ready);
    modport sink   (input valid, input func, input reg_offset,
                    input access_bytes, input write_data, output ready);
endinterface

### hdl/smfr_rsp_if.sv
// Response channel: one result per bus access.
// Depends on smfr_pkg for field widths.
interface smfr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [smfr_pkg::DATA_W-1:0]   read_data;
    logic                          bus_error;
    logic                          irq_level;

    modport source (output valid, output read_data, output bus_error,
                    output irq_level, input ready);
    modport sink   (input valid, input read_data, input bus_error,
                    input irq_level, output ready);
endinterface

### hdl/spi_master_flash_model_regs_core.sv
// SPI master register block with a simulated serial flash and RX byte FIFO.
// Depends on smfr_pkg, smfr_req_if and smfr_rsp_if.
//
//   Channel   Direction   Beat carries
//   req       in          func, reg_offset, access_bytes, write_data
//   rsp       out         read_data, bus_error, irq_level
//
// Each access passes through the request register and then waits in the
// response register until it is taken. One access is taken every cycle
// while the response side keeps up; the register state is updated in the
// cycle the access leaves the request register, ready for the next one.
// A stalled response holds the request register; a new beat is still taken
// while the request register is empty or draining into the response stage.
// Reset clears all control registers at once; the FIFO storage is not reset.
module spi_master_flash_model_regs_core
(
    input  logic           clk,
    input  logic           rst_n,
    smfr_req_if.sink       req,
    smfr_rsp_if.source     rsp
);

    // Flash read sequencer phases. The fourth encoding is never entered and
    // would behave like the data phase.
    typedef enum logic [1:0]
    {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Request register.
    logic                               s1_valid_reg;
    logic                               s1_func_reg;
    logic [smfr_pkg::OFS_W-1:0]         s1_ofs_reg;
    logic [smfr_pkg::SIZE_W-1:0]        s1_size_reg;
    logic [smfr_pkg::DATA_W-1:0]        s1_wdata_reg;

    // Architectural state.
    logic [smfr_pkg::DATA_W-1:0]        ctrl_reg,  ctrl_next;
    logic [smfr_pkg::DATA_W-1:0]        div_reg,   div_next;
    logic [1:0]                         ie_reg,    ie_next;
    logic [1:0]                         busy_reg,  busy_next;
    phase_t                             phase_reg, phase_next;
    logic [smfr_pkg::FL_PTR_W-1:0]      ptr_reg,   ptr_next;
    logic [smfr_pkg::RX_IDX_W-1:0]      head_reg,  head_next;
    logic [smfr_pkg::RX_CNT_W-1:0]      count_reg, count_next;
    logic [7:0]                         rx_store_reg [smfr_pkg::RX_DEPTH];

    // Response register.
    logic                               out_valid_reg;
    logic [smfr_pkg::DATA_W-1:0]        out_rdata_reg, out_rdata_next;
    logic                               out_err_reg,   out_err_next;
    logic                               out_irq_reg,   out_irq_next;

    // Handshake and datapath signals.
    logic                               req_fire;
    logic                               advance;
    logic                               fire;
    logic [smfr_pkg::DATA_W-1:0]        size_mask;
    logic [smfr_pkg::DATA_W-1:0]        wval;
    logic [smfr_pkg::DATA_W-1:0]        rval;
    logic [7:0]                         tx_byte;
    logic [7:0]                         rx_byte;
    logic                               push;
    logic [smfr_pkg::RX_CNT_W:0]        push_sum;
    logic [smfr_pkg::RX_IDX_W-1:0]      push_idx;

    // The response stage frees up when it is empty or being taken; the
    // request register may then hand its access over and take a new beat.
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.bus_error = out_err_reg;
    assign rsp.irq_level = out_irq_reg;

    // Byte lane mask from the access size; zero bytes mask everything off.
    always_comb
    begin
        case (s1_size_reg)
            4'd0:    size_mask = 32'h0000_0000;
            4'd1:    size_mask = 32'h0000_00FF;
            4'd2:    size_mask = 32'h0000_FFFF;
            4'd3:    size_mask = 32'h00FF_FFFF;
            default: size_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign wval    = s1_wdata_reg & size_mask;
    assign tx_byte = wval[7:0];

    // The pushed byte lands at head plus count, wrapped once at most.
    assign push_sum = (smfr_pkg::RX_CNT_W + 1)'(head_reg)
                    + (smfr_pkg::RX_CNT_W + 1)'(count_reg);
    assign push_idx = (push_sum >= (smfr_pkg::RX_CNT_W + 1)'(smfr_pkg::RX_DEPTH))
                    ? smfr_pkg::RX_IDX_W'(push_sum
                        - (smfr_pkg::RX_CNT_W + 1)'(smfr_pkg::RX_DEPTH))
                    : smfr_pkg::RX_IDX_W'(push_sum);

    // One access: decode, update the state, form the result.
    always_comb
    begin
        ctrl_next      = ctrl_reg;
        div_next       = div_reg;
        ie_next        = ie_reg;
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        ptr_next       = ptr_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rval           = '0;
        rx_byte        = '0;
        push           = 1'b0;
        out_err_next   = 1'b0;

        if (fire)
        begin
            if (s1_ofs_reg > smfr_pkg::OFS_LIMIT)
            begin
                out_err_next = 1'b1;
            end
            else if (s1_func_reg == smfr_pkg::FUNC_WRITE)
            begin
                case (s1_ofs_reg)
                    smfr_pkg::OFS_CTRL:
                    begin
                        ctrl_next = wval;
                        // Deselecting every chip select ends a flash read.
                        if (((wval & smfr_pkg::CS_MASK) == smfr_pkg::CS_MASK)
                            && ((ctrl_reg & smfr_pkg::CS_MASK) != smfr_pkg::CS_MASK))
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    smfr_pkg::OFS_DIV:
                    begin
                        div_next = wval;
                    end
                    smfr_pkg::OFS_TX:
                    begin
                        if (ctrl_reg[smfr_pkg::LOOPBACK_BIT])
                        begin
                            rx_byte = tx_byte;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_IDLE:
                                begin
                                    if (tx_byte == smfr_pkg::CMD_READ)
                                    begin
                                        phase_next = PH_CMD;
                                    end
                                end
                                PH_CMD:
                                begin
                                    ptr_next   = smfr_pkg::ADDR_TAB[tx_byte];
                                    phase_next = PH_DATA;
                                end
                                default:
                                begin
                                    // The flash returns its own address.
                                    rx_byte = 8'(ptr_reg);
                                    if (ptr_reg == smfr_pkg::FL_PTR_W'(smfr_pkg::FLASH_BYTES - 1))
                                    begin
                                        ptr_next = '0;
                                    end
                                    else
                                    begin
                                        ptr_next = ptr_reg + 1'b1;
                                    end
                                end
                            endcase
                        end
                        // A full FIFO drops the byte.
                        if (count_reg < smfr_pkg::RX_CNT_W'(smfr_pkg::RX_DEPTH))
                        begin
                            push       = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        busy_next = smfr_pkg::BUSY_LOAD;
                    end
                    smfr_pkg::OFS_IE:
                    begin
                        ie_next = wval[1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (s1_ofs_reg)
                    smfr_pkg::OFS_CTRL:
                    begin
                        rval = ctrl_reg;
                    end
                    smfr_pkg::OFS_DIV:
                    begin
                        rval = div_reg;
                    end
                    smfr_pkg::OFS_RX:
                    begin
                        if (count_reg != '0)
                        begin
                            rval       = {24'd0, rx_store_reg[head_reg]};
                            count_next = count_reg - 1'b1;
                            if (head_reg == smfr_pkg::RX_IDX_W'(smfr_pkg::RX_DEPTH - 1))
                            begin
                                head_next = '0;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                    end
                    smfr_pkg::OFS_STATUS:
                    begin
                        rval[0] = busy_reg > 2'd1;
                        rval[1] = count_reg < smfr_pkg::RX_CNT_W'(smfr_pkg::RX_DEPTH);
                        rval[2] = count_reg != '0;
                        rval[3] = 1'b1;
                        rval[4] = count_reg >= smfr_pkg::RX_CNT_W'(smfr_pkg::RX_DEPTH);
                        // Reading the status ticks the busy countdown.
                        if (busy_reg != 2'd0)
                        begin
                            busy_next = busy_reg - 1'b1;
                        end
                    end
                    smfr_pkg::OFS_IE:
                    begin
                        rval = {30'd0, ie_reg};
                    end
                    smfr_pkg::OFS_IS:
                    begin
                        rval = {30'd0, 1'b1, count_reg != '0};
                    end
                    smfr_pkg::OFS_CAP:
                    begin
                        rval = smfr_pkg::CAP_VALUE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        out_rdata_next = rval & size_mask;
        out_irq_next   = ie_next[0] && (count_next != '0);
    end

    // Control state, sequencer and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= smfr_pkg::CTRL_RESET;
            div_reg       <= '0;
            ie_reg        <= '0;
            busy_reg      <= '0;
            phase_reg     <= PH_IDLE;
            ptr_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_err_reg   <= 1'b0;
            out_irq_reg   <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                out_err_reg   <= out_err_next;
                out_irq_reg   <= out_irq_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            ctrl_reg  <= ctrl_next;
            div_reg   <= div_next;
            ie_reg    <= ie_next;
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Payload registers and FIFO storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_func_reg  <= req.func;
            s1_ofs_reg   <= req.reg_offset;
            s1_size_reg  <= req.access_bytes;
            s1_wdata_reg <= req.write_data;
        end
        if (fire)
        begin
            out_rdata_reg <= out_rdata_next;
        end
        if (push)
        begin
            rx_store_reg[push_idx] <= rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= smfr_pkg::RX_CNT_W'(smfr_pkg::RX_DEPTH))
        else $error("RX FIFO count exceeds its depth");

    a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg <= smfr_pkg::BUSY_LOAD)
        else $error("busy countdown above its load value");

    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rsp.irq_level == (ie_reg[0] && (count_reg != '0))))
        else $error("IRQ level does not match state after the access");

    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_ofs_reg > smfr_pkg::OFS_LIMIT))
        |=> ($stable(ctrl_reg) && $stable(count_reg) && $stable(phase_reg)
             && $stable(busy_reg)))
        else $error("bus error access changed register state");

    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.bus_error) |-> (rsp.read_data == '0))
        else $error("bus error beat carries read data");
`endif

endmodule

### dv/smfr_regs_checker.sv
`timescale 1ns / 100ps
// Checker for the SPI master register block: watches the request and response
// channels, predicts each result and compares it. Depends on smfr_pkg and on
// the smfr_req_if and smfr_rsp_if interfaces.
module smfr_regs_checker
(
    input  logic   clk,
    input  logic   rst_n,
    smfr_req_if    req,
    smfr_rsp_if    rsp,
    output int     mismatches,
    output int     backlog,
    output int     checked,
    output int     flash_bytes,
    output int     dropped
);

    // Room for predicted results that have not been taken yet; the block
    // never holds more than two.
    localparam int OWED_SLOTS = 8;

    typedef enum logic [1:0] {FLASH_IDLE, FLASH_ADDR, FLASH_DATA, FLASH_SPARE} flash_phase_t;

    typedef struct packed {
        logic [smfr_pkg::DATA_W-1:0] read_data;
        logic                        bus_error;
        logic                        irq_level;
    } access_outcome_t;

    // Shadow copy of the register block.
    logic [smfr_pkg::DATA_W-1:0]   ctrl_q;
    logic [smfr_pkg::DATA_W-1:0]   div_q;
    logic [1:0]                    ie_q;
    logic [1:0]                    busy_q;
    flash_phase_t                  phase_q;
    logic [smfr_pkg::FL_PTR_W-1:0] ptr_q;
    logic [7:0]                    rx_bytes [smfr_pkg::RX_DEPTH];
    logic [smfr_pkg::RX_IDX_W-1:0] rx_head_q;
    logic [smfr_pkg::RX_CNT_W-1:0] rx_fill_q;

    access_outcome_t owed_outcomes [OWED_SLOTS];
    int              owed_in;
    int              owed_out;
    access_outcome_t fresh;
    access_outcome_t want;

    // Applies one bus access to the shadow state and returns its outcome.
    function automatic access_outcome_t apply_access(input logic wr,
            input logic [smfr_pkg::OFS_W-1:0] ofs,
            input logic [smfr_pkg::SIZE_W-1:0] nbytes,
            input logic [smfr_pkg::DATA_W-1:0] wdata);
        access_outcome_t             res;
        logic [smfr_pkg::DATA_W-1:0] keep;
        logic [smfr_pkg::DATA_W-1:0] val;
        logic [smfr_pkg::DATA_W-1:0] word;
        logic [7:0]                  back;
        res  = '0;
        word = '0;
        case (nbytes)
            4'd0:    keep = 32'h0000_0000;
            4'd1:    keep = 32'h0000_00FF;
            4'd2:    keep = 32'h0000_FFFF;
            4'd3:    keep = 32'h00FF_FFFF;
            default: keep = 32'hFFFF_FFFF;
        endcase
        val = wdata & keep;
        if (ofs > smfr_pkg::OFS_LIMIT)
        begin
            res.bus_error = 1'b1;
        end
        else if (wr == smfr_pkg::FUNC_WRITE)
        begin
            case (ofs)
                smfr_pkg::OFS_CTRL:
                begin
                    if ((val & smfr_pkg::CS_MASK) == smfr_pkg::CS_MASK
                        && (ctrl_q & smfr_pkg::CS_MASK) != smfr_pkg::CS_MASK)
                        phase_q = FLASH_IDLE;
                    ctrl_q = val;
                end
                smfr_pkg::OFS_DIV: div_q = val;
                smfr_pkg::OFS_TX:
                begin
                    back = 8'h00;
                    if (ctrl_q[smfr_pkg::LOOPBACK_BIT])
                    begin
                        back = val[7:0];
                    end
                    else if (phase_q == FLASH_IDLE)
                    begin
                        if (val[7:0] == smfr_pkg::CMD_READ)
                            phase_q = FLASH_ADDR;
                    end
                    else if (phase_q == FLASH_ADDR)
                    begin
                        ptr_q   = smfr_pkg::FL_PTR_W'(int'(val[7:0]) % smfr_pkg::FLASH_BYTES);
                        phase_q = FLASH_DATA;
                    end
                    else
                    begin
                        back  = 8'(ptr_q);
                        ptr_q = smfr_pkg::FL_PTR_W'((int'(ptr_q) + 1) % smfr_pkg::FLASH_BYTES);
                        flash_bytes++;
                    end
                    if (rx_fill_q < smfr_pkg::RX_DEPTH)
                    begin
                        rx_bytes[(int'(rx_head_q) + int'(rx_fill_q)) % smfr_pkg::RX_DEPTH] = back;
                        rx_fill_q = rx_fill_q + 1'b1;
                    end
                    else
                    begin
                        dropped++;
                    end
                    busy_q = smfr_pkg::BUSY_LOAD;
                end
                smfr_pkg::OFS_IE: ie_q = val[1:0];
                default: ;
            endcase
        end
        else
        begin
            case (ofs)
                smfr_pkg::OFS_CTRL: word = ctrl_q;
                smfr_pkg::OFS_DIV:  word = div_q;
                smfr_pkg::OFS_RX:
                begin
                    if (rx_fill_q != 0)
                    begin
                        word      = {24'h0, rx_bytes[rx_head_q]};
                        rx_head_q = smfr_pkg::RX_IDX_W'((int'(rx_head_q) + 1)
                                                        % smfr_pkg::RX_DEPTH);
                        rx_fill_q = rx_fill_q - 1'b1;
                    end
                end
                smfr_pkg::OFS_STATUS:
                begin
                    word = {27'h0, rx_fill_q >= smfr_pkg::RX_DEPTH, 1'b1, rx_fill_q != 0,
                            rx_fill_q < smfr_pkg::RX_DEPTH, busy_q > 2'd1};
                    if (busy_q != 0)
                        busy_q = busy_q - 1'b1;
                end
                smfr_pkg::OFS_IE:  word = {30'h0, ie_q};
                smfr_pkg::OFS_IS:  word = {30'h0, 1'b1, rx_fill_q != 0};
                smfr_pkg::OFS_CAP: word = {8'h01, 8'h04, 8'(smfr_pkg::RX_DEPTH),
                                           8'(smfr_pkg::RX_DEPTH)};
                default: ;
            endcase
            res.read_data = word & keep;
        end
        res.irq_level = ie_q[0] && (rx_fill_q != 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_q    = smfr_pkg::CTRL_RESET;
            div_q     = '0;
            ie_q      = '0;
            busy_q    = '0;
            phase_q   = FLASH_IDLE;
            ptr_q     = '0;
            rx_head_q = '0;
            rx_fill_q = '0;
            owed_in   = 0;
            owed_out  = 0;
            backlog   = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                fresh = apply_access(req.func, req.reg_offset,
                                     req.access_bytes, req.write_data);
                if (owed_in - owed_out >= OWED_SLOTS)
                begin
                    mismatches++;
                    $display("%0t: results owed expected at most %0d, actual %0d",
                             $time, OWED_SLOTS, owed_in - owed_out + 1);
                end
                else
                begin
                    owed_outcomes[owed_in % OWED_SLOTS] = fresh;
                    owed_in++;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (owed_in == owed_out)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, got data %h err %b irq %b",
                             $time, rsp.read_data, rsp.bus_error, rsp.irq_level);
                end
                else
                begin
                    want = owed_outcomes[owed_out % OWED_SLOTS];
                    owed_out++;
                    checked++;
                    if (rsp.read_data !== want.read_data)
                    begin
                        mismatches++;
                        $display("%0t: read_data expected %h, actual %h",
                                 $time, want.read_data, rsp.read_data);
                    end
                    if (rsp.bus_error !== want.bus_error)
                    begin
                        mismatches++;
                        $display("%0t: bus_error expected %b, actual %b",
                                 $time, want.bus_error, rsp.bus_error);
                    end
                    if (rsp.irq_level !== want.irq_level)
                    begin
                        mismatches++;
                        $display("%0t: irq_level expected %b, actual %b",
                                 $time, want.irq_level, rsp.irq_level);
                    end
                end
            end
            backlog = owed_in - owed_out;
        end
    end

endmodule

### dv/tb_spi_master_flash_model_regs_core.sv
`timescale 1ns / 100ps
// Top of the testbench for the SPI master register block: drives bus accesses,
// stalls the response side and gives the verdict. Depends on smfr_pkg, the two
// channel interfaces, smfr_regs_checker and the block itself.
module tb_spi_master_flash_model_regs_core;

    // Directed accesses come first, then roughly this many random ones.
    localparam int DIRECTED_MAX    = 29;
    localparam int RANDOM_ITEMS    = 1321;
    // One random group adds at most a few dozen accesses past the target.
    localparam int PLAN_SLOTS      = DIRECTED_MAX + RANDOM_ITEMS + 64;
    // The long receiver hold-off starts once this many beats have gone in.
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int HOLD_OFF_CYCLES = 60;
    // Wait after the last result, to make sure nothing stray follows it.
    localparam int TAIL_CYCLES     = 8;
    localparam int LIMIT_NS        = 4_000_000;

    typedef struct {
        logic                        func;
        logic [smfr_pkg::OFS_W-1:0]  ofs;
        logic [smfr_pkg::SIZE_W-1:0] nbytes;
        logic [smfr_pkg::DATA_W-1:0] data;
    } bus_access_t;

    logic clk;
    logic rst_n;
    int   beats_taken;
    int   mismatches;
    int   backlog;
    int   checked;
    int   flash_bytes;
    int   dropped;

    bus_access_t access_plan [PLAN_SLOTS];
    int          plan_len;

    smfr_req_if req_ch ();
    smfr_rsp_if rsp_ch ();

    spi_master_flash_model_regs_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    smfr_regs_checker watch
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .backlog     (backlog),
        .checked     (checked),
        .flash_bytes (flash_bytes),
        .dropped     (dropped)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void enqueue_access(input logic f,
            input logic [smfr_pkg::OFS_W-1:0] o,
            input logic [smfr_pkg::SIZE_W-1:0] n,
            input logic [smfr_pkg::DATA_W-1:0] d);
        bus_access_t a;
        a.func   = f;
        a.ofs    = o;
        a.nbytes = n;
        a.data   = d;
        access_plan[plan_len] = a;
        plan_len++;
    endfunction

    // Stimulus and verdict.
    initial
    begin : stimulus
        int                          pick;
        int                          n;
        int                          k;
        int                          burst_left;
        int                          gap;
        logic [smfr_pkg::DATA_W-1:0] v;
        logic [smfr_pkg::OFS_W-1:0]  o;

        rst_n               = 1'b0;
        beats_taken         = 0;
        plan_len            = 0;
        req_ch.valid        = 1'b0;
        req_ch.func         = smfr_pkg::FUNC_READ;
        req_ch.reg_offset   = '0;
        req_ch.access_bytes = '0;
        req_ch.write_data   = '0;

        // Directed part. The capability word is read at full, byte, zero and
        // oversize widths, then both kinds of bus error and the unaligned
        // offsets, which must read as zero and swallow writes.
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_CAP, 4'd4,  32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_CAP, 4'd1,  32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_CAP, 4'd0,  32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_CAP, 4'd15, 32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  12'hFFF, 4'd4,  32'hFFFF_FFFF);
        enqueue_access(smfr_pkg::FUNC_WRITE, 12'h01D, 4'd8,  32'hFFFF_FFFF);
        enqueue_access(smfr_pkg::FUNC_READ,  12'h002, 4'd4,  32'h0);
        enqueue_access(smfr_pkg::FUNC_WRITE, 12'h005, 4'd4,  32'hFFFF_FFFF);
        // Interrupt enable is masked to its two bits.
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_IE, 4'd4, 32'hFFFF_FFFF);
        // Drop all chip selects with loopback off, then a complete flash read
        // whose address is the last byte, so that the second data byte shows
        // the pointer wrap.
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_CTRL, 4'd4, 32'h0000_0001);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX, 4'd1,
                       {24'hFFFFFF, smfr_pkg::CMD_READ});
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX, 4'd2, 32'h0000_00FF);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX, 4'd4, 32'h0);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX, 4'd4, 32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_STATUS, 4'd4, 32'h0);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_IS, 4'd4, 32'h0);
        for (k = 0; k < 4; k++)
            enqueue_access(smfr_pkg::FUNC_READ, smfr_pkg::OFS_RX, 4'd1, 32'h0);
        // Popping an empty FIFO reads zero.
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_RX, 4'd4, 32'h0);
        // All selects high again with loopback on: the byte is echoed.
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_CTRL, 4'd4, 32'h0000_00F9);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX, 4'd8, 32'hDEAD_BEA5);
        // Writes to a read-only register go nowhere.
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_STATUS, 4'd4, 32'hFFFF_FFFF);
        // A zero-size write stores zero; partial sizes mask the data.
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_DIV, 4'd0,  32'hFFFF_FFFF);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_DIV, 4'd2,  32'h1234_5678);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_DIV, 4'd3,  32'h0);
        enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_DIV, 4'd8,  32'hFFFF_FFFF);
        enqueue_access(smfr_pkg::FUNC_READ,  smfr_pkg::OFS_DIV, 4'd15, 32'h0);

        // Random part. Most of it is well-formed flash read sequences and
        // FIFO fill-and-drain runs; the rest is register traffic and noise
        // across the whole offset range.
        while (plan_len < DIRECTED_MAX + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                v = $urandom;
                v[7:4] = 4'($urandom_range(0, 14));
                v[smfr_pkg::LOOPBACK_BIT] = ($urandom_range(0, 4) == 0);
                enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_CTRL,
                               4'($urandom_range(4, 15)), v);
                v = $urandom;
                if ($urandom_range(0, 9) != 0)
                    v[7:0] = smfr_pkg::CMD_READ;
                enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX,
                               4'($urandom_range(1, 15)), v);
                // Address byte followed by data bytes.
                n = $urandom_range(1, 7);
                for (k = 0; k < n; k++)
                    enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX,
                                   4'($urandom_range(1, 15)), $urandom);
                n = $urandom_range(0, n + 2);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 5))
                        0:       o = smfr_pkg::OFS_STATUS;
                        1:       o = smfr_pkg::OFS_IS;
                        default: o = smfr_pkg::OFS_RX;
                    endcase
                    enqueue_access(smfr_pkg::FUNC_READ, o, 4'($urandom_range(1, 4)), $urandom);
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    v = $urandom;
                    v[7:4] = 4'hF;
                    enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_CTRL,
                                   4'($urandom_range(4, 15)), v);
                end
            end
            else if (pick < 50)
            begin
                // Between 12 and 20 sends, which can reach a full FIFO and drop bytes past it.
                n = $urandom_range(12, 20);
                for (k = 0; k < n; k++)
                    enqueue_access(smfr_pkg::FUNC_WRITE, smfr_pkg::OFS_TX,
                                   4'($urandom_range(0, 15)), $urandom);
                enqueue_access(smfr_pkg::FUNC_READ, smfr_pkg::OFS_STATUS,
                               4'($urandom_range(1, 15)), $urandom);
                n = $urandom_range(0, 20);
                for (k = 0; k < n; k++)
                    enqueue_access(smfr_pkg::FUNC_READ, smfr_pkg::OFS_RX,
                                   4'($urandom_range(0, 15)), $urandom);
            end
            else if (pick < 70)
            begin
                enqueue_access(1'($urandom_range(0, 1)),
                               smfr_pkg::OFS_W'(4 * $urandom_range(0, 7)),
                               4'($urandom_range(0, 15)), $urandom);
            end
            else if (pick < 85)
            begin
                enqueue_access(1'($urandom_range(0, 1)),
                               smfr_pkg::OFS_W'($urandom_range(0, 28)),
                               4'($urandom_range(0, 15)), $urandom);
            end
            else
            begin
                enqueue_access(1'($urandom_range(0, 1)),
                               smfr_pkg::OFS_W'($urandom_range(0, 4095)),
                               4'($urandom_range(0, 15)), $urandom);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender: bursts of random length with random gaps between them. A
        // zero gap joins two bursts, which gives longer stretches of
        // back-to-back beats.
        burst_left = 0;
        for (k = 0; k < plan_len; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            req_ch.valid        <= 1'b1;
            req_ch.func         <= access_plan[k].func;
            req_ch.reg_offset   <= access_plan[k].ofs;
            req_ch.access_bytes <= access_plan[k].nbytes;
            req_ch.write_data   <= access_plan[k].data;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            beats_taken++;
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed result, sampling away from the clock edge so
        // the checker has settled its count.
        do
            @(negedge clk);
        while (backlog != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d accesses and compared %0d results, with flash reads, loopback,",
                 beats_taken, checked);
        $display("bus errors and a full FIFO: %0d flash data bytes, %0d bytes dropped.",
                 flash_bytes, dropped);
        if (mismatches == 0)
            $display("tb_spi_master_flash_model_regs_core OK");
        else
            $display("tb_spi_master_flash_model_regs_core NOT OK");
        $finish;
    end

    // Receiver: changes its stall style every so often. Style 0 never stalls,
    // style 1 takes about seven beats in ten, style 2 takes one in three. Once
    // enough beats have gone in, ready is held low for a long stretch so the
    // block fills up and has to stall its own input.
    initial
    begin : drain_side
        int  stretch;
        int  style;
        int  k;
        bit  held;
        rsp_ch.ready = 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(20, 150);
            for (k = 0; k < stretch; k++)
            begin
                @(posedge clk);
                if (!held && beats_taken >= HOLD_OFF_AFTER)
                begin
                    held = 1'b1;
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    default: rsp_ch.ready <= (k % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog for a hung handshake or a result that never comes.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("tb_spi_master_flash_model_regs_core NOT OK");
        $finish;
    end

endmodule

### spi_master_flash_model_regs_core.f
hdl/smfr_pkg.sv
hdl/smfr_req_if.sv
hdl/smfr_rsp_if.sv
hdl/spi_master_flash_model_regs_core.sv
dv/smfr_regs_checker.sv
dv/tb_spi_master_flash_model_regs_core.sv
